/* rtl/lmtf_pkg.sv */
// Shared types and constants for the move-to-front LRU cache.
package lmtf_pkg;

   localparam int DEPTH       = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = 5;

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_PEEK   = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      cmd_type                 command;
      logic [KEY_WIDTH-1:0]    key;
      logic [VALUE_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [VALUE_WIDTH-1:0]  found_value;
      logic                    released_valid;
      logic [KEY_WIDTH-1:0]    released_key;
      logic [VALUE_WIDTH-1:0]  released_value;
      logic [CNT_W-1:0]        occupancy;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic lookup;
      logic update;
   } ctl_cmd_type;

endpackage

/* rtl/lru_move_to_front_cache.sv */
// Top level: LRU key/value cache kept as a move-to-front recency list.
// Each request passes through a lookup state, for the parallel key compare over
// all entries, and an update state, for the recency shift of the entry registers;
// a new request is accepted while idle or as the previous update commits.
// Reset: empty store, capacity 16, no result pending; entry data is not cleared.
// A capacity write empties the store in the same cycle.
module lru_move_to_front_cache (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lmtf_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lmtf_pkg::rsp_type   rsp_payload,
   input  logic                csr_write_enable,
   input  logic [lmtf_pkg::CNT_W-1:0] csr_write_data
);
   import lmtf_pkg::*;

   ctl_cmd_type cmd;

   // Sequencer
   lmtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Entry storage and result
   lmtf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

/* rtl/lmtf_ctrl.sv */
// Controller state machine: request intake, lookup and update sequencing.
module lmtf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lmtf_pkg::ctl_cmd_type cmd
);
   import lmtf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;
   logic      accept;

   // Update may finish once the output register is free or being drained
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd.load_req = accept;
      cmd.lookup   = 1'b0;
      cmd.update   = 1'b0;
      case (state_ff)
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = commit;
         end
         default: begin
            cmd.lookup = 1'b0;
         end
      endcase
   end

   // Output valid: set on update, drop when the request result is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> state_ff == ST_UPDATE)
      else $error("lookup not followed by update");

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted request did not start lookup");

   a_commit_fills_output: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("update did not present a result");

endmodule

/* rtl/lmtf_datapath.sv */
// Datapath: entry registers, parallel key compare, recency shift and result register.
module lmtf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lmtf_pkg::ctl_cmd_type cmd,
   input  lmtf_pkg::req_type    req_payload,
   output lmtf_pkg::rsp_type    rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [lmtf_pkg::CNT_W-1:0] csr_write_data
);
   import lmtf_pkg::*;

   req_type                req_ff;
   logic [KEY_WIDTH-1:0]   entry_key_ff   [DEPTH];
   logic [KEY_WIDTH-1:0]   entry_key_in   [DEPTH];
   logic [VALUE_WIDTH-1:0] entry_value_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] entry_value_in [DEPTH];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       cap_ff, cap_in;

   logic                   hit_ff, full_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [KEY_WIDTH-1:0]   sel_key_ff;
   logic [VALUE_WIDTH-1:0] sel_value_ff;
   rsp_type                rsp_ff, rsp_in;

   logic                   lk_hit;
   logic [IDX_W-1:0]       lk_hit_idx;
   logic                   lk_full;
   logic [IDX_W-1:0]       lk_pos;

   logic                   is_insert, is_remove, is_find;
   logic                   shift_back, shift_front, grow, shrink, released;

   // Hold the request
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_payload;
   end

   // Compare all live entries, first match wins
   always_comb begin
      lk_hit     = 1'b0;
      lk_hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < count_ff) && (entry_key_ff[i] == req_ff.key)) begin
            lk_hit     = 1'b1;
            lk_hit_idx = IDX_W'(i);
         end
      end
      lk_full = (count_ff >= cap_ff);
      if (lk_hit)       lk_pos = lk_hit_idx;
      else if (lk_full) lk_pos = IDX_W'(count_ff - CNT_W'(1));
      else              lk_pos = IDX_W'(count_ff);
   end

   // Register lookup outcome and the entry at the selected slot
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff       <= lk_hit;
         full_ff      <= lk_full;
         pos_ff       <= lk_pos;
         sel_key_ff   <= entry_key_ff[lk_pos];
         sel_value_ff <= entry_value_ff[lk_pos];
      end
   end

   assign is_insert   = (req_ff.command == CMD_INSERT);
   assign is_remove   = (req_ff.command == CMD_REMOVE);
   assign is_find     = (req_ff.command == CMD_FIND);
   assign shift_back  = is_insert || (is_find && hit_ff);
   assign shift_front = is_remove && hit_ff;
   assign grow        = is_insert && !hit_ff && !full_ff;
   assign shrink      = shift_front;
   assign released    = is_insert && (hit_ff || full_ff);

   // Move entries: push toward the back up to pos, or close the gap at pos
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_key_in[i]   = entry_key_ff[i];
         entry_value_in[i] = entry_value_ff[i];
         if (cmd.update && shift_back) begin
            if (i == 0) begin
               entry_key_in[i]   = is_insert ? req_ff.key   : sel_key_ff;
               entry_value_in[i] = is_insert ? req_ff.value : sel_value_ff;
            end else if (IDX_W'(i) <= pos_ff) begin
               entry_key_in[i]   = entry_key_ff[(i + DEPTH - 1) % DEPTH];
               entry_value_in[i] = entry_value_ff[(i + DEPTH - 1) % DEPTH];
            end
         end else if (cmd.update && shift_front) begin
            if ((IDX_W'(i) >= pos_ff) && (i < DEPTH - 1)) begin
               entry_key_in[i]   = entry_key_ff[(i + 1) % DEPTH];
               entry_value_in[i] = entry_value_ff[(i + 1) % DEPTH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_key_ff[i]   <= entry_key_in[i];
         entry_value_ff[i] <= entry_value_in[i];
      end
   end

   // Occupancy and capacity; a capacity write empties the store
   always_comb begin
      count_in = count_ff;
      cap_in   = cap_ff;
      if (cmd.update && grow)   count_in = count_ff + CNT_W'(1);
      if (cmd.update && shrink) count_in = count_ff - CNT_W'(1);
      if (csr_write_enable) begin
         count_in = '0;
         if (csr_write_data == '0)                  cap_in = CNT_W'(1);
         else if (csr_write_data > CNT_W'(DEPTH))   cap_in = CNT_W'(DEPTH);
         else                                       cap_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CNT_W'(DEPTH);
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   // Build the result
   always_comb begin
      rsp_in.status         = !(is_insert || hit_ff);
      rsp_in.found_value    = (!is_insert && hit_ff) ? sel_value_ff : '0;
      rsp_in.released_valid = released;
      rsp_in.released_key   = released ? sel_key_ff : '0;
      rsp_in.released_value = released ? sel_value_ff : '0;
      rsp_in.occupancy      = count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.update) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("occupancy above capacity");

   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      (cap_ff != '0) && (cap_ff <= CNT_W'(DEPTH)))
      else $error("capacity out of range");

   a_insert_miss_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.update && grow && !csr_write_enable |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert into free slot did not raise occupancy");

endmodule
